@@ sv/golden_section_minimum_search_defines.svh @@
// ----------------------------------------------------------------------------
// golden section search assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GOLDEN_SECTION_MINIMUM_SEARCH_DEFINES_SVH
`define GOLDEN_SECTION_MINIMUM_SEARCH_DEFINES_SVH

// same-cycle implication, off during reset
`define GSS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define GSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also active during reset
`define GSS_ASSERT_RST(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/gss_pkg.sv @@
// ----------------------------------------------------------------------------
// gss_pkg
// shared codes, control struct and constants of the golden section search
// ----------------------------------------------------------------------------
package gss_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int TOL_WIDTH   = 31;

  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd66;

  // floor(2^32 / phi)
  localparam logic [31:0] INV_PHI_Q32 = 32'd2654435769;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_VALUE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_EVAL    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_IGNORED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_LEFT  = 2'd1,
    PEND_RIGHT = 2'd2
  } pend_t;

  typedef struct packed {
    logic  need_left;
    logic  need_right;
    pend_t pending;
  } ctl_t;

endpackage

@@ sv/gss_offset.sv @@
// ----------------------------------------------------------------------------
// gss_offset
// golden inner offset: floor(width * INV_PHI_Q32 / 2^32)
// ----------------------------------------------------------------------------
module gss_offset #(
  parameter int POS_WIDTH = 32
) (
  input  logic [POS_WIDTH-1:0] width_in,
  output logic [POS_WIDTH-1:0] offset
);

  generate
    if (POS_WIDTH > 32) begin : g_wide
      logic [63:0]          low_prod;
      logic [POS_WIDTH-1:0] high_prod;
      assign low_prod  = 64'(width_in[31:0]) * 64'(gss_pkg::INV_PHI_Q32);
      assign high_prod = POS_WIDTH'(width_in[POS_WIDTH-1:32]) *
                         POS_WIDTH'(gss_pkg::INV_PHI_Q32);
      assign offset    = high_prod + POS_WIDTH'(low_prod[63:32]);
    end else begin : g_narrow
      logic [63:0] prod;
      assign prod   = 64'(width_in) * 64'(gss_pkg::INV_PHI_Q32);
      assign offset = POS_WIDTH'(prod[63:32]);
    end
  endgenerate

endmodule

@@ sv/gss_step.sv @@
// ----------------------------------------------------------------------------
// gss_step
// next search state and result for one item
// ----------------------------------------------------------------------------
module gss_step #(
  parameter int POS_WIDTH = 32
) (
  input  logic                                cmd,
  input  logic signed [gss_pkg::FIELD_WIDTH-1:0] lo_bound,
  input  logic signed [gss_pkg::FIELD_WIDTH-1:0] hi_bound,
  input  logic signed [gss_pkg::FIELD_WIDTH-1:0] fvalue,
  input  logic [gss_pkg::TOL_WIDTH-1:0]       tolerance,
  input  logic [POS_WIDTH-1:0]                lo_q,
  input  logic [POS_WIDTH-1:0]                hi_q,
  input  logic [POS_WIDTH-1:0]                lp_q,
  input  logic [POS_WIDTH-1:0]                rp_q,
  input  logic signed [gss_pkg::FIELD_WIDTH-1:0] lv_q,
  input  logic signed [gss_pkg::FIELD_WIDTH-1:0] rv_q,
  input  gss_pkg::ctl_t                       ctl_q,
  output logic [POS_WIDTH-1:0]                lo_nxt,
  output logic [POS_WIDTH-1:0]                hi_nxt,
  output logic [POS_WIDTH-1:0]                lp_nxt,
  output logic [POS_WIDTH-1:0]                rp_nxt,
  output logic signed [gss_pkg::FIELD_WIDTH-1:0] lv_nxt,
  output logic signed [gss_pkg::FIELD_WIDTH-1:0] rv_nxt,
  output gss_pkg::ctl_t                       ctl_nxt,
  output gss_pkg::kind_t                      kind,
  output logic [gss_pkg::FIELD_WIDTH-1:0]     point
);

  localparam int CW = (POS_WIDTH > gss_pkg::TOL_WIDTH) ? POS_WIDTH : gss_pkg::TOL_WIDTH;

  logic [POS_WIDTH-1:0]                  b_lo, b_hi;
  logic [POS_WIDTH-1:0]                  lo_a, hi_a, lp_a, rp_a;
  logic signed [gss_pkg::FIELD_WIDTH-1:0] lv_a, rv_a;
  gss_pkg::ctl_t                         ctl_a;
  logic                                  run;
  logic [POS_WIDTH-1:0]                  width;
  logic [POS_WIDTH-1:0]                  off;
  logic [POS_WIDTH-1:0]                  pt;

  assign b_lo = POS_WIDTH'(lo_bound);
  assign b_hi = POS_WIDTH'(hi_bound);

  // load or take the value, then narrow
  always_comb begin
    lo_a  = lo_q;
    hi_a  = hi_q;
    lp_a  = lp_q;
    rp_a  = rp_q;
    lv_a  = lv_q;
    rv_a  = rv_q;
    ctl_a = ctl_q;
    run   = 1'b0;
    if (gss_pkg::cmd_t'(cmd) == gss_pkg::CMD_START) begin
      if ($signed(b_lo) > $signed(b_hi)) begin
        lo_a = b_hi;
        hi_a = b_lo;
      end else begin
        lo_a = b_lo;
        hi_a = b_hi;
      end
      ctl_a.need_left  = 1'b1;
      ctl_a.need_right = 1'b1;
      run              = 1'b1;
    end else begin
      case (ctl_q.pending)
        gss_pkg::PEND_LEFT: begin
          lv_a            = fvalue;
          ctl_a.need_left = 1'b0;
          run             = 1'b1;
        end
        gss_pkg::PEND_RIGHT: begin
          rv_a             = fvalue;
          ctl_a.need_right = 1'b0;
          run              = 1'b1;
        end
        default: run = 1'b0;
      endcase
      if (run && !ctl_a.need_left && !ctl_a.need_right) begin
        if (lv_a >= rv_a) begin
          lo_a             = lp_q;
          lp_a             = rp_q;
          lv_a             = rv_a;
          ctl_a.need_right = 1'b1;
        end else begin
          hi_a            = rp_q;
          rp_a            = lp_q;
          rv_a            = lv_a;
          ctl_a.need_left = 1'b1;
        end
      end
    end
  end

  assign width = hi_a - lo_a;

  gss_offset #(
    .POS_WIDTH (POS_WIDTH)
  ) u_offset (
    .width_in (width),
    .offset   (off)
  );

  // next request or finish; an item with no pending value is ignored
  always_comb begin
    lo_nxt  = lo_a;
    hi_nxt  = hi_a;
    lp_nxt  = lp_a;
    rp_nxt  = rp_a;
    lv_nxt  = lv_a;
    rv_nxt  = rv_a;
    ctl_nxt = ctl_a;
    kind    = gss_pkg::KIND_IGNORED;
    pt      = '0;
    if (run) begin
      if (CW'(width) <= CW'(tolerance)) begin
        ctl_nxt.pending = gss_pkg::PEND_NONE;
        kind            = gss_pkg::KIND_DONE;
        pt              = lo_a + (width >> 1);
      end else if (ctl_a.need_left) begin
        lp_nxt          = hi_a - off;
        ctl_nxt.pending = gss_pkg::PEND_LEFT;
        kind            = gss_pkg::KIND_EVAL;
        pt              = hi_a - off;
      end else if (ctl_a.need_right) begin
        rp_nxt          = lo_a + off;
        ctl_nxt.pending = gss_pkg::PEND_RIGHT;
        kind            = gss_pkg::KIND_EVAL;
        pt              = lo_a + off;
      end else begin
        ctl_nxt.pending = gss_pkg::PEND_NONE;
        kind            = gss_pkg::KIND_DONE;
        pt              = lo_a + (width >> 1);
      end
    end
  end

  assign point = gss_pkg::FIELD_WIDTH'($signed(pt));

endmodule

@@ sv/golden_section_minimum_search.sv @@
// ----------------------------------------------------------------------------
// golden_section_minimum_search
// golden section minimum search controller with an external objective
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_cmd, in_lo_bound, in_hi_bound, in_fvalue
//   out_     out  out_valid/out_ready  out_kind, out_point, out_lo_out, out_hi_out
//   cfg_     in   cfg_valid/cfg_ready  cfg_tolerance
//
// one item per cycle sustained while out_ready is high; an item passes the input
// register, then the step logic with the offset multiply into the result register
// synchronous reset clears the search state, tolerance goes to 66
// a stalled result holds; one more item waits in the input register
// cfg_ready is always high
// ----------------------------------------------------------------------------
module golden_section_minimum_search #(
  parameter int POS_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [gss_pkg::FIELD_WIDTH-1:0] in_lo_bound,
  input  logic signed [gss_pkg::FIELD_WIDTH-1:0] in_hi_bound,
  input  logic signed [gss_pkg::FIELD_WIDTH-1:0] in_fvalue,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_kind,
  output logic signed [gss_pkg::FIELD_WIDTH-1:0] out_point,
  output logic signed [gss_pkg::FIELD_WIDTH-1:0] out_lo_out,
  output logic signed [gss_pkg::FIELD_WIDTH-1:0] out_hi_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gss_pkg::TOL_WIDTH-1:0]       cfg_tolerance
);

  logic [gss_pkg::TOL_WIDTH-1:0]         tol_r;

  logic                                  s1_valid_r;
  logic                                  s1_cmd_r;
  logic signed [gss_pkg::FIELD_WIDTH-1:0] s1_lo_r, s1_hi_r, s1_fv_r;
  logic                                  s1_adv;

  logic [POS_WIDTH-1:0]                  lo_r, hi_r, lp_r, rp_r;
  logic [POS_WIDTH-1:0]                  lo_nxt, hi_nxt, lp_nxt, rp_nxt;
  logic signed [gss_pkg::FIELD_WIDTH-1:0] lv_r, rv_r, lv_nxt, rv_nxt;
  gss_pkg::ctl_t                         ctl_r, ctl_nxt;
  gss_pkg::kind_t                        kind_nxt;
  logic [gss_pkg::FIELD_WIDTH-1:0]       point_nxt;

  logic                                  out_valid_r;
  gss_pkg::kind_t                        out_kind_r;
  logic [gss_pkg::FIELD_WIDTH-1:0]       out_point_r, out_lo_r, out_hi_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= gss_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_tolerance;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r <= in_cmd;
      s1_lo_r  <= in_lo_bound;
      s1_hi_r  <= in_hi_bound;
      s1_fv_r  <= in_fvalue;
    end
  end

  gss_step #(
    .POS_WIDTH (POS_WIDTH)
  ) u_step (
    .cmd       (s1_cmd_r),
    .lo_bound  (s1_lo_r),
    .hi_bound  (s1_hi_r),
    .fvalue    (s1_fv_r),
    .tolerance (tol_r),
    .lo_q      (lo_r),
    .hi_q      (hi_r),
    .lp_q      (lp_r),
    .rp_q      (rp_r),
    .lv_q      (lv_r),
    .rv_q      (rv_r),
    .ctl_q     (ctl_r),
    .lo_nxt    (lo_nxt),
    .hi_nxt    (hi_nxt),
    .lp_nxt    (lp_nxt),
    .rp_nxt    (rp_nxt),
    .lv_nxt    (lv_nxt),
    .rv_nxt    (rv_nxt),
    .ctl_nxt   (ctl_nxt),
    .kind      (kind_nxt),
    .point     (point_nxt)
  );

  // search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r  <= '0;
      hi_r  <= '0;
      lp_r  <= '0;
      rp_r  <= '0;
      lv_r  <= '0;
      rv_r  <= '0;
      ctl_r <= '{need_left: 1'b1, need_right: 1'b1, pending: gss_pkg::PEND_NONE};
    end else if (s1_adv) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      lp_r  <= lp_nxt;
      rp_r  <= rp_nxt;
      lv_r  <= lv_nxt;
      rv_r  <= rv_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r  <= kind_nxt;
      out_point_r <= point_nxt;
      out_lo_r    <= gss_pkg::FIELD_WIDTH'($signed(lo_nxt));
      out_hi_r    <= gss_pkg::FIELD_WIDTH'($signed(hi_nxt));
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_point  = out_point_r;
  assign out_lo_out = out_lo_r;
  assign out_hi_out = out_hi_r;

endmodule

@@ sv/gss_check.sv @@
// ----------------------------------------------------------------------------
// gss_check
// port-level checks of the golden section search, bound to the top level
// ----------------------------------------------------------------------------
`include "golden_section_minimum_search_defines.svh"

module gss_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic [31:0] in_lo_bound,
  input logic [31:0] in_hi_bound,
  input logic [31:0] in_fvalue,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_point,
  input logic [31:0] out_lo_out,
  input logic [31:0] out_hi_out,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [30:0] cfg_tolerance
);

  `GSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_kind) && $stable(out_point) &&
                   $stable(out_lo_out) && $stable(out_hi_out),
                   "stalled item changed")
  `GSS_ASSERT_IMPL(a_ignored_point, out_valid && out_kind == gss_pkg::KIND_IGNORED,
                   out_point == 32'd0, "ignored item with nonzero point")
  `GSS_ASSERT_RST(a_reset_idle, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind golden_section_minimum_search gss_check u_gss_check (.*);
